FILE: design/frsm_pkg.sv
// ============================================================================
// frsm_pkg: shared definitions for the flash record slot manager
// Field widths, status codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ============================================================================
package frsm_pkg;

    // Default geometry of the emulated flash page.
    localparam int PAGE_BYTES_DEF   = 1024;
    localparam int RECORD_WORDS_DEF = 8;

    // Fixed field widths of the channels.
    localparam int HW_W       = 16;
    localparam int WI_W       = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_WRITE_PROTECT = 2'd0;

    // An erased flash halfword.
    localparam logic [HW_W-1:0] ERASED_HW = 16'hFFFF;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_NODATA  = 3'd1,
        STAT_CORRUPT = 3'd2,
        STAT_WPROT   = 3'd3,
        STAT_PGERR   = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DECIDE,
        ST_ROUTE,
        ST_ERASE,
        ST_LOAD_RD,
        ST_LOAD_DATA,
        ST_PROG_RD,
        ST_PROG_CHECK,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;        // latch the input item
        logic clear_start;   // restart the erase sweep and drop the erase request
        logic clear_step;    // write one erased cell and advance the sweep
        logic scan_start;    // restart the header scan
        logic scan_step;     // issue one header read and check the previous one
        logic decide;        // resolve the item from the scan result and state
        logic load_issue;    // read the requested cell of the latest record
        logic load_capture;  // take the read cell as result data
        logic prog_issue;    // read the cell about to be programmed
        logic prog_commit;   // program the cell if it is still erased
        logic out_load;      // move the result into the output register
    } frsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;    // the sweep is at the last cell
        logic scan_done;     // the scan stops in this cycle
        logic need_scan;     // the latched item needs a header scan
        logic erase_pend;    // the page must be erased before programming
        logic load_pend;     // a load must read one cell
        logic prog_pend;     // a store must program one cell
    } frsm_stat_t;

endpackage

FILE: design/frsm_channels.sv
// ============================================================================
// frsm channels: valid/ready channel interfaces of the slot manager
// The input channel carries one load or store request, the output channel
// carries one result per request.
// ============================================================================
interface frsm_in_if;
    import frsm_pkg::*;

    logic            valid;
    logic            ready;
    logic            op;
    logic [WI_W-1:0] word_index;
    logic [HW_W-1:0] value;

    modport source (output valid, output op, output word_index, output value, input ready);
    modport sink   (input valid, input op, input word_index, input value, output ready);
endinterface

interface frsm_out_if;
    import frsm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [HW_W-1:0]       data;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  page_erased;

    modport source (output valid, output data, output status, output slot,
                    output page_erased, input ready);
    modport sink   (input valid, input data, input status, input slot,
                    input page_erased, output ready);
endinterface

FILE: design/frsm_datapath.sv
// ============================================================================
// frsm_datapath: page memory, scan counters and result registers
// Holds the flash page, walks the record headers, resolves loads and stores
// and keeps the write protection register of the configuration port.
// ============================================================================
module frsm_datapath #(
    parameter int PAGE_BYTES   = frsm_pkg::PAGE_BYTES_DEF,
    parameter int RECORD_WORDS = frsm_pkg::RECORD_WORDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  frsm_pkg::frsm_cmd_t               cmd,
    output frsm_pkg::frsm_stat_t              stat,
    input  logic                              in_op,
    input  logic [frsm_pkg::WI_W-1:0]         in_word_index,
    input  logic [frsm_pkg::HW_W-1:0]         in_value,
    output logic [frsm_pkg::HW_W-1:0]         out_data,
    output logic [frsm_pkg::STATUS_W-1:0]     out_status,
    output logic [frsm_pkg::SLOT_OUT_W-1:0]   out_slot,
    output logic                              out_page_erased,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [frsm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [frsm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [frsm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import frsm_pkg::*;

    localparam int PAGE_HW    = PAGE_BYTES / 2;
    localparam int SLOT_COUNT = PAGE_BYTES / (RECORD_WORDS * 2);
    localparam int ADDR_W     = $clog2(PAGE_HW);
    localparam int SLOT_W     = (SLOT_COUNT < 1) ? 1 : $clog2(SLOT_COUNT + 1);
    localparam logic [HW_W-1:0]   HEADER_OK  = HW_W'(RECORD_WORDS * 2);
    localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOT_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(PAGE_HW - 1);

    // Page memory with registered read data.
    logic [HW_W-1:0]   page_mem [PAGE_HW];
    logic [HW_W-1:0]   rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [HW_W-1:0]   mem_wdata;

    // Item, scan and result registers.
    logic              op_reg;
    logic [WI_W-1:0]   wi_reg;
    logic [HW_W-1:0]   value_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [SLOT_W-1:0] scan_issue_reg;
    logic [SLOT_W-1:0] scan_eval_reg;
    logic              scan_pend_reg;
    logic [SLOT_W-1:0] scan_n_reg;
    logic              scan_corrupt_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [SLOT_W-1:0] target_slot_reg;
    logic              store_aborted_reg;
    logic              wp_reg;
    logic              erase_pend_reg;
    logic              load_pend_reg;
    logic              prog_pend_reg;
    status_t           res_status_reg;
    logic              res_erased_reg;
    logic [HW_W-1:0]   res_data_reg;
    logic [HW_W-1:0]   out_data_reg;
    status_t           out_status_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic              out_erased_reg;

    // Derived values.
    logic [ADDR_W-1:0] cell_addr;
    logic              issue_lt;
    logic              hdr_ok;
    logic              scan_stop;
    logic              need_erase;
    logic [SLOT_W-1:0] start_slot;
    logic              wi_in_rec;
    logic              slot_bad;
    logic              prog_ok;
    logic              cfg_write;

    // Resolution of the latched item.
    status_t           dec_status;
    logic [SLOT_W-1:0] dec_slot;
    logic              dec_erase;
    logic              dec_load;
    logic              dec_prog;
    logic [SLOT_W-1:0] dec_target;
    logic              dec_aborted;

    // Address of the addressed cell and the decisions that follow from the scan.
    always_comb
    begin
        cell_addr  = ADDR_W'(32'(cur_slot_reg) * RECORD_WORDS + 32'(wi_reg));
        issue_lt   = scan_issue_reg < SLOT_LIMIT;
        hdr_ok     = rd_data_reg == HEADER_OK;
        scan_stop  = scan_pend_reg ? !hdr_ok : (scan_issue_reg == SLOT_LIMIT);
        need_erase = scan_corrupt_reg || (scan_n_reg == SLOT_LIMIT);
        start_slot = need_erase ? '0 : scan_n_reg;
        wi_in_rec  = 32'(wi_reg) < RECORD_WORDS;
        slot_bad   = 32'(cur_slot_reg) >= SLOT_COUNT;
        prog_ok    = !slot_bad && (rd_data_reg == ERASED_HW);
        cfg_write  = psel && penable && pwrite && (paddr == ADDR_WRITE_PROTECT);
    end

    // Resolve the item from the scan result and the store state.
    always_comb
    begin
        dec_status  = STAT_OK;
        dec_slot    = '0;
        dec_erase   = 1'b0;
        dec_load    = 1'b0;
        dec_prog    = 1'b0;
        dec_target  = target_slot_reg;
        dec_aborted = store_aborted_reg;
        if (op_reg == OP_LOAD)
        begin
            if (scan_corrupt_reg)
            begin
                dec_status = STAT_CORRUPT;
            end
            else if (scan_n_reg == '0)
            begin
                dec_status = STAT_NODATA;
            end
            else
            begin
                dec_slot = scan_n_reg - 1'b1;
                dec_load = wi_in_rec;
            end
        end
        else if (wi_reg == '0)
        begin
            dec_slot = start_slot;
            if (wp_reg)
            begin
                dec_status  = STAT_WPROT;
                dec_aborted = 1'b1;
            end
            else
            begin
                dec_target  = start_slot;
                dec_aborted = 1'b0;
                dec_erase   = need_erase;
                dec_prog    = 1'b1;
            end
        end
        else
        begin
            dec_slot = target_slot_reg;
            if (store_aborted_reg || wp_reg)
            begin
                dec_status = STAT_WPROT;
            end
            else
            begin
                dec_prog = wi_in_rec;
            end
        end
    end

    // Memory port selection.
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = cell_addr;
        mem_we    = 1'b0;
        mem_waddr = cell_addr;
        mem_wdata = value_reg;
        if (cmd.scan_step && issue_lt)
        begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(32'(scan_issue_reg) * RECORD_WORDS);
        end
        if ((cmd.load_issue || cmd.prog_issue) && !slot_bad)
        begin
            rd_en = 1'b1;
        end
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = ERASED_HW;
        end
        else if (cmd.prog_commit && prog_ok)
        begin
            mem_we = 1'b1;
        end
    end

    // Page memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= page_mem[rd_addr];
        end
    end

    // Control registers: sweep, scan, slot bookkeeping and result status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg            <= OP_LOAD;
            wi_reg            <= '0;
            clr_addr_reg      <= '0;
            scan_issue_reg    <= '0;
            scan_eval_reg     <= '0;
            scan_pend_reg     <= 1'b0;
            scan_n_reg        <= '0;
            scan_corrupt_reg  <= 1'b0;
            cur_slot_reg      <= '0;
            target_slot_reg   <= '0;
            store_aborted_reg <= 1'b0;
            wp_reg            <= 1'b0;
            erase_pend_reg    <= 1'b0;
            load_pend_reg     <= 1'b0;
            prog_pend_reg     <= 1'b0;
            res_status_reg    <= STAT_OK;
            res_erased_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                wp_reg <= pwdata[0];
            end

            if (cmd.accept)
            begin
                op_reg <= in_op;
                wi_reg <= in_word_index;
            end

            // Erase sweep, one cell a cycle.
            if (cmd.clear_start)
            begin
                clr_addr_reg   <= '0;
                erase_pend_reg <= 1'b0;
            end
            else if (cmd.clear_step)
            begin
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + 1'b1;
            end

            // Header scan: one read issued and one header checked each cycle.
            if (cmd.scan_start)
            begin
                scan_issue_reg <= '0;
                scan_pend_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_pend_reg <= issue_lt;
                if (issue_lt)
                begin
                    scan_issue_reg <= scan_issue_reg + 1'b1;
                    scan_eval_reg  <= scan_issue_reg;
                end
                if (scan_stop)
                begin
                    scan_n_reg       <= scan_pend_reg ? scan_eval_reg : scan_issue_reg;
                    scan_corrupt_reg <= scan_pend_reg && !hdr_ok && (rd_data_reg != ERASED_HW);
                end
            end

            // Take the resolution once the scan result is known.
            if (cmd.decide)
            begin
                res_status_reg    <= dec_status;
                res_erased_reg    <= dec_erase;
                cur_slot_reg      <= dec_slot;
                erase_pend_reg    <= dec_erase;
                load_pend_reg     <= dec_load;
                prog_pend_reg     <= dec_prog;
                target_slot_reg   <= dec_target;
                store_aborted_reg <= dec_aborted;
            end

            if (cmd.load_capture)
            begin
                load_pend_reg <= 1'b0;
            end

            // A cell that is not erased, or a slot off the page, is a program error.
            if (cmd.prog_commit)
            begin
                prog_pend_reg  <= 1'b0;
                res_status_reg <= prog_ok ? STAT_OK : STAT_PGERR;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            value_reg <= in_value;
        end
        if (cmd.decide)
        begin
            res_data_reg <= '0;
        end
        else if (cmd.load_capture)
        begin
            res_data_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg   <= res_data_reg;
            out_status_reg <= res_status_reg;
            out_slot_reg   <= SLOT_OUT_W'(cur_slot_reg);
            out_erased_reg <= res_erased_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.clear_last = clr_addr_reg == LAST_ADDR;
        stat.scan_done  = scan_stop;
        stat.need_scan  = (op_reg == OP_LOAD) || (wi_reg == '0);
        stat.erase_pend = erase_pend_reg;
        stat.load_pend  = load_pend_reg;
        stat.prog_pend  = prog_pend_reg;
    end

    assign out_data        = out_data_reg;
    assign out_status      = out_status_reg;
    assign out_slot        = out_slot_reg;
    assign out_page_erased = out_erased_reg;

    // Configuration read back; the port never waits.
    assign prdata = (paddr == ADDR_WRITE_PROTECT) ? APB_DATA_W'(wp_reg) : '0;
    assign pready = 1'b1;

endmodule

FILE: design/frsm_ctrl.sv
// ============================================================================
// frsm_ctrl: sequencing state machine of the slot manager
// Runs the reset clearing pass, takes one request at a time, steps the
// datapath through scan, erase, read or program, and owns the output valid.
// ============================================================================
module frsm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  frsm_pkg::frsm_stat_t stat,
    output frsm_pkg::frsm_cmd_t  cmd
);
    import frsm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = stat.need_scan ? ST_SCAN : ST_DECIDE;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                if (stat.erase_pend)
                begin
                    state_next = ST_ERASE;
                end
                else if (stat.load_pend)
                begin
                    state_next = ST_LOAD_RD;
                end
                else if (stat.prog_pend)
                begin
                    state_next = ST_PROG_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ERASE:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_ROUTE;
                end
            end
            ST_LOAD_RD:    state_next = ST_LOAD_DATA;
            ST_LOAD_DATA:  state_next = ST_DONE;
            ST_PROG_RD:    state_next = ST_PROG_CHECK;
            ST_PROG_CHECK: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:      cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_DISPATCH:   cmd.scan_start   = stat.need_scan;
            ST_SCAN:       cmd.scan_step    = 1'b1;
            ST_DECIDE:     cmd.decide       = 1'b1;
            ST_ROUTE:      cmd.clear_start  = stat.erase_pend;
            ST_ERASE:      cmd.clear_step   = 1'b1;
            ST_LOAD_RD:    cmd.load_issue   = 1'b1;
            ST_LOAD_DATA:  cmd.load_capture = 1'b1;
            ST_PROG_RD:    cmd.prog_issue   = 1'b1;
            ST_PROG_CHECK: cmd.prog_commit  = 1'b1;
            ST_DONE:       cmd.out_load     = out_free;
            default:       cmd = '0;
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/flash_record_slot_manager.sv
// ============================================================================
// flash_record_slot_manager: append log of fixed-size records in one page
// Top level joining the sequencing controller and the page datapath.
// ============================================================================
// Usage:
// Requests arrive on in_ch (op, word_index, value) and each one yields exactly
// one transfer on out_ch (data, status, slot, page_erased). A load returns one
// halfword of the latest good record; a store programs one halfword, and word
// 0 of a store picks the next free slot, erasing the page first if needed.
// The write_protect register sits at byte address 0 of the APB-style port;
// writes take effect with pready tied high.
// A load or the first word of a store walks the record headers at one
// header per cycle from the single memory read port, and a store may first
// erase the page, one cell per cycle, before it programs its cell.
// One request is in work at a time; in_ch.ready is high only between items.
// After reset all PAGE_BYTES/2 cells (512 by default) are swept to the erased
// value with in_ch.ready low; the APB port works throughout.
// A stalled receiver holds the result in the output register while the next
// request is accepted and worked; that request waits for the register to free.
// ============================================================================
module flash_record_slot_manager #(
    parameter int PAGE_BYTES   = frsm_pkg::PAGE_BYTES_DEF,
    parameter int RECORD_WORDS = frsm_pkg::RECORD_WORDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    frsm_in_if.sink                         in_ch,
    frsm_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [frsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [frsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [frsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import frsm_pkg::*;

    frsm_cmd_t  cmd;
    frsm_stat_t stat;

    // Sequencing controller.
    frsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Page memory and result datapath.
    frsm_datapath #(
        .PAGE_BYTES   (PAGE_BYTES),
        .RECORD_WORDS (RECORD_WORDS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (in_ch.op),
        .in_word_index   (in_ch.word_index),
        .in_value        (in_ch.value),
        .out_data        (out_ch.data),
        .out_status      (out_ch.status),
        .out_slot        (out_ch.slot),
        .out_page_erased (out_ch.page_erased),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

endmodule

FILE: design/frsm_checker.sv
// ============================================================================
// frsm_checker: port-level checks of the flash record slot manager
// Watches the channels of the top level and is attached to it by bind.
// ============================================================================
module frsm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [frsm_pkg::HW_W-1:0]         out_data,
    input logic [frsm_pkg::STATUS_W-1:0]     out_status,
    input logic [frsm_pkg::SLOT_OUT_W-1:0]   out_slot,
    input logic                              out_page_erased
);
    import frsm_pkg::*;

    // A result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_status)
            && $stable(out_slot) && $stable(out_page_erased))
        else $error("result changed while stalled");

    // One request is worked at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    // Only a successful load carries data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != STAT_OK) |-> out_data == '0)
        else $error("data on a failed result");

    // An erase always restarts the log at slot 0 and never comes with a refusal.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_page_erased |-> out_slot == '0
            && (out_status == STAT_OK || out_status == STAT_PGERR))
        else $error("erase reported with a wrong slot or status");

    // A load without a record reports no slot and no erase.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == STAT_NODATA || out_status == STAT_CORRUPT)
            |-> out_slot == '0 && !out_page_erased)
        else $error("missing record reported with a slot");

endmodule

bind flash_record_slot_manager frsm_checker u_frsm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data        (out_ch.data),
    .out_status      (out_ch.status),
    .out_slot        (out_ch.slot),
    .out_page_erased (out_ch.page_erased)
);
